// File: design/mmcp_pkg.sv
// ----------------------------------------------------------------------------
// mmcp_pkg: shared types and constants
// Field widths and the control/status bundles between the sequencer and the
// walk unit.
// ----------------------------------------------------------------------------
package mmcp_pkg;

    localparam int ITEM_W   = 16;  // item_size port width
    localparam int GROUPS_W = 11;  // num_groups register width
    localparam int RESULT_W = 26;  // best_max_sum port width

    typedef struct packed {
        logic start;               // launch one probe
    } t_walk_ctl;

    typedef struct packed {
        logic busy;
        logic done;                // one-cycle pulse at end of probe
        logic fit;                 // probe bound is feasible, valid with done
    } t_walk_sts;

endpackage

// File: design/mmcp_intf.sv
// ----------------------------------------------------------------------------
// mmcp channel interfaces
// Valid/ready channels for item input, result output and config writes.
// ----------------------------------------------------------------------------
interface mmcp_item_if;
    logic                          valid;
    logic                          ready;
    logic [mmcp_pkg::ITEM_W-1:0]   item_size;
    logic                          is_last;

    modport source (output valid, output item_size, output is_last, input ready);
    modport sink   (input valid, input item_size, input is_last, output ready);
endinterface

interface mmcp_result_if;
    logic                          valid;
    logic                          ready;
    logic [mmcp_pkg::RESULT_W-1:0] best_max_sum;
    logic                          no_solution;

    modport source (output valid, output best_max_sum, output no_solution, input ready);
    modport sink   (input valid, input best_max_sum, input no_solution, output ready);
endinterface

interface mmcp_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mmcp_pkg::GROUPS_W-1:0] num_groups;

    modport source (output valid, output num_groups, input ready);
    modport sink   (input valid, input num_groups, output ready);
endinterface

// File: design/mmcp_store.sv
// ----------------------------------------------------------------------------
// mmcp_store: item size memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mmcp_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/mmcp_walk.sv
// ----------------------------------------------------------------------------
// mmcp_walk: greedy feasibility walk
// Streams the stored sizes once per probe through one add/compare unit and
// counts the groups needed for the given bound.
// ----------------------------------------------------------------------------
module mmcp_walk #(
    parameter int CNT_W     = 11,
    parameter int SIZE_BITS = 16,
    parameter int AW        = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mmcp_pkg::t_walk_ctl             i_ctl,
    input  logic [SIZE_BITS+CNT_W-1:0]      i_bound,
    input  logic [mmcp_pkg::GROUPS_W-1:0]   i_groups,
    input  logic [CNT_W-1:0]                i_count,
    output logic                            o_rd_en,
    output logic [AW-1:0]                   o_rd_addr,
    input  logic [SIZE_BITS-1:0]            i_rd_data,
    output mmcp_pkg::t_walk_sts             o_sts
);

    localparam int SUM_W = SIZE_BITS + CNT_W;

    logic             r_busy;
    logic             r_done;
    logic             r_fit;
    logic             r_pend;
    logic [CNT_W-1:0] r_issue;
    logic [CNT_W-1:0] r_proc;
    logic [CNT_W-1:0] r_used;
    logic [SUM_W-1:0] r_acc;

    logic [SUM_W-1:0] w_v;
    logic [SUM_W:0]   w_sum;
    logic             w_over;
    logic             w_fits;
    logic [CNT_W-1:0] w_used_nxt;
    logic [CNT_W-1:0] w_proc_inc;
    logic             w_last;
    logic             w_grp_ok;

    always_comb begin
        w_v        = {{CNT_W{1'b0}}, i_rd_data};
        w_sum      = {1'b0, r_acc} + {1'b0, w_v};
        w_over     = w_v > i_bound;
        w_fits     = w_sum <= {1'b0, i_bound};
        w_used_nxt = w_fits ? r_used : r_used + CNT_W'(1);
        w_proc_inc = r_proc + CNT_W'(1);
        w_last     = w_proc_inc == i_count;
        w_grp_ok   = {{mmcp_pkg::GROUPS_W{1'b0}}, w_used_nxt}
                     <= {{CNT_W{1'b0}}, i_groups};
        o_rd_en    = r_busy && (r_issue < i_count);
        o_rd_addr  = r_issue[AW-1:0];
        o_sts      = '{busy: r_busy, done: r_done, fit: r_fit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_fit   <= 1'b0;
            r_pend  <= 1'b0;
            r_issue <= '0;
            r_proc  <= '0;
            r_used  <= '0;
            r_acc   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy  <= 1'b1;
                r_pend  <= 1'b0;
                r_issue <= '0;
                r_proc  <= '0;
                r_used  <= CNT_W'(1);
                r_acc   <= '0;
            end else if (r_busy) begin
                r_pend <= o_rd_en;
                if (o_rd_en) begin
                    r_issue <= r_issue + CNT_W'(1);
                end
                if (r_pend) begin
                    r_proc <= w_proc_inc;
                    r_used <= w_used_nxt;
                    r_acc  <= w_fits ? w_sum[SUM_W-1:0] : w_v;
                    if (w_over) begin
                        // single item larger than the bound
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                        r_fit  <= 1'b0;
                    end else if (w_last) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                        r_fit  <= w_grp_ok;
                    end
                end
            end
        end
    end

endmodule

// File: design/min_max_contiguous_partition_core.sv
// ----------------------------------------------------------------------------
// min_max_contiguous_partition_core: linear partition by binary search
// Loads item sizes, then finds the smallest largest-group sum over at most
// num_groups contiguous groups.
// ----------------------------------------------------------------------------
// Items load at one transaction per cycle; each is written to the size memory
// and added to the running total. The item marked last starts the search and
// the input stays not ready until the result is handed to the output
// register. The search is a binary search of the bound over [0, total]: at
// most floor(log2(total+1)) + 1 probes, each one greedy walk over the N
// held items through the walk unit's single add/compare datapath, one item
// per cycle from the memory read port (a walk ends early when a single item
// exceeds the bound). When num_groups is zero or larger than the item count
// the result is no_solution = 1 with best_max_sum = 0, passed through the
// S_FIN state to the output register once that register is free.
// Items beyond MAX_ITEMS are dropped (a dropped last item still starts the
// search). Config writes are always ready; the user must write them during
// idle periods only, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module min_max_contiguous_partition_core #(
    parameter int MAX_ITEMS = 1024,
    parameter int SIZE_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    mmcp_item_if.sink          i_item,
    mmcp_cfg_if.sink           i_cfg,
    mmcp_result_if.source      o_result
);

    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int AW     = $clog2(MAX_ITEMS);
    localparam int SUM_W  = SIZE_BITS + CNT_W;
    localparam int SRCH_W = SUM_W + 1;
    localparam int ITEM_W = mmcp_pkg::ITEM_W;
    localparam int RES_W  = mmcp_pkg::RESULT_W;

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;  // loading items
    localparam logic [1:0] S_PROBE = 2'd1;  // pick next bound
    localparam logic [1:0] S_WAIT  = 2'd2;  // walk in progress
    localparam logic [1:0] S_FIN   = 2'd3;  // hand result to output reg

    logic [1:0]                      r_state, n_state;
    logic [CNT_W-1:0]                r_count, n_count;
    logic [SUM_W-1:0]                r_total, n_total;
    logic [SRCH_W-1:0]               r_low,   n_low;
    logic [SUM_W-1:0]                r_high,  n_high;
    logic [SUM_W-1:0]                r_mid,   n_mid;
    logic [SUM_W-1:0]                r_best,  n_best;
    logic                            r_none,  n_none;
    logic [mmcp_pkg::GROUPS_W-1:0]   r_groups;
    logic                            r_out_vld, n_out_vld;
    logic [RES_W-1:0]                r_out_best, n_out_best;
    logic                            r_out_none, n_out_none;

    logic                            w_in_acc;
    logic                            w_full;
    logic [ITEM_W+SIZE_BITS-1:0]     w_size_ext;
    logic [SIZE_BITS-1:0]            w_size;
    logic [CNT_W-1:0]                w_count_nxt;
    logic [SUM_W-1:0]                w_total_nxt;
    logic                            w_no_sol;
    logic [SRCH_W-1:0]               w_diff;
    logic [SRCH_W-1:0]               w_mid_w;
    logic [SUM_W+RES_W-1:0]          w_best_ext;

    mmcp_pkg::t_walk_ctl             w_ctl;
    mmcp_pkg::t_walk_sts             w_sts;
    logic                            w_rd_en;
    logic [AW-1:0]                   w_rd_addr;
    logic [SIZE_BITS-1:0]            w_rd_data;

    // size memory: written while loading, read by the walk
    mmcp_store #(
        .DEPTH (MAX_ITEMS),
        .AW    (AW),
        .DW    (SIZE_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && !w_full),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_size),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    mmcp_walk #(
        .CNT_W     (CNT_W),
        .SIZE_BITS (SIZE_BITS),
        .AW        (AW)
    ) u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_bound   (r_mid),
        .i_groups  (r_groups),
        .i_count   (r_count),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data),
        .o_sts     (w_sts)
    );

    assign i_item.ready          = (r_state == S_IDLE);
    assign i_cfg.ready           = 1'b1;
    assign o_result.valid        = r_out_vld;
    assign o_result.best_max_sum = r_out_best;
    assign o_result.no_solution  = r_out_none;

    always_comb begin
        // input size masked to SIZE_BITS (zero-extended when wider)
        w_size_ext  = {{SIZE_BITS{1'b0}}, i_item.item_size};
        w_size      = w_size_ext[SIZE_BITS-1:0];
        w_in_acc    = i_item.valid && i_item.ready;
        w_full      = (r_count == CNT_W'(MAX_ITEMS));
        w_count_nxt = w_full ? r_count : r_count + CNT_W'(1);
        w_total_nxt = w_full ? r_total : r_total + {{CNT_W{1'b0}}, w_size};
        w_no_sol    = (r_groups == '0) ||
                      ({{CNT_W{1'b0}}, r_groups} >
                       {{mmcp_pkg::GROUPS_W{1'b0}}, w_count_nxt});
        w_diff      = {1'b0, r_high} - r_low;
        w_mid_w     = r_low + (w_diff >> 1);
        w_best_ext  = {{RES_W{1'b0}}, r_best};

        n_state    = r_state;
        n_count    = r_count;
        n_total    = r_total;
        n_low      = r_low;
        n_high     = r_high;
        n_mid      = r_mid;
        n_best     = r_best;
        n_none     = r_none;
        n_out_vld  = r_out_vld && !o_result.ready;
        n_out_best = r_out_best;
        n_out_none = r_out_none;
        w_ctl      = '{start: 1'b0};

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_count = w_count_nxt;
                    n_total = w_total_nxt;
                    if (i_item.is_last) begin
                        n_none = w_no_sol;
                        if (w_no_sol) begin
                            n_best  = '0;
                            n_state = S_FIN;
                        end else begin
                            n_low   = '0;
                            n_high  = w_total_nxt;
                            n_best  = w_total_nxt;
                            n_state = S_PROBE;
                        end
                    end
                end
            end
            S_PROBE: begin
                if (r_low <= {1'b0, r_high}) begin
                    n_mid   = w_mid_w[SUM_W-1:0];
                    w_ctl   = '{start: 1'b1};
                    n_state = S_WAIT;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_WAIT: begin
                if (w_sts.done) begin
                    if (w_sts.fit) begin
                        n_best = r_mid;
                        if (r_mid == '0) begin
                            n_state = S_FIN;
                        end else begin
                            n_high  = r_mid - SUM_W'(1);
                            n_state = S_PROBE;
                        end
                    end else begin
                        n_low   = {1'b0, r_mid} + SRCH_W'(1);
                        n_state = S_PROBE;
                    end
                end
            end
            S_FIN: begin
                // wait for a free output register, then clear the list
                if (!r_out_vld || o_result.ready) begin
                    n_out_vld  = 1'b1;
                    n_out_best = r_none ? '0 : w_best_ext[RES_W-1:0];
                    n_out_none = r_none;
                    n_count    = '0;
                    n_total    = '0;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_total   <= '0;
            r_low     <= '0;
            r_high    <= '0;
            r_mid     <= '0;
            r_best    <= '0;
            r_none    <= 1'b0;
            r_out_vld <= 1'b0;
            r_groups  <= mmcp_pkg::GROUPS_W'(1);
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_total   <= n_total;
            r_low     <= n_low;
            r_high    <= n_high;
            r_mid     <= n_mid;
            r_best    <= n_best;
            r_none    <= n_none;
            r_out_vld <= n_out_vld;
            if (i_cfg.valid && i_cfg.ready) begin
                r_groups <= i_cfg.num_groups;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_out_best <= n_out_best;
        r_out_none <= n_out_none;
    end

endmodule

// File: tb/sv/tb_min_max_contiguous_partition_core.sv
// ----------------------------------------------------------------------------
// tb_min_max_contiguous_partition_core: self-checking bench for the partition core
// Streams lists of book page counts and writes the group count between lists.
// A local bench model predicts each minimum largest-group sum by its own
// binary search with a greedy walk. Results are compared in order, and both
// channel sides idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb_min_max_contiguous_partition_core;

    localparam int ITEM_W   = mmcp_pkg::ITEM_W;
    localparam int RESULT_W = mmcp_pkg::RESULT_W;
    localparam int GROUPS_W = mmcp_pkg::GROUPS_W;

    localparam int SHELF_DEPTH = 1024;     // store depth the core is built with
    localparam int ITEM_TARGET = 1550;     // stop queueing new phases past this
    localparam int CALM_TAIL   = 150;      // items at the end sent with no idling
    localparam int QUIET_LIMIT = 150000;   // cycles without any transaction

    typedef struct packed {
        logic [ITEM_W-1:0] pages;
        logic              last;
    } t_book;

    typedef struct packed {
        logic [RESULT_W-1:0] best_max_sum;
        logic                no_solution;
    } t_split;

    logic i_clk;
    logic i_rst_n;

    mmcp_item_if   book_bus ();
    mmcp_cfg_if    cfg_bus ();
    mmcp_result_if split_bus ();

    min_max_contiguous_partition_core #(
        .MAX_ITEMS (SHELF_DEPTH),
        .SIZE_BITS (ITEM_W)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (book_bus),
        .i_cfg    (cfg_bus),
        .o_result (split_bus)
    );

    // Bench copy of the core's state, advanced on accepted transactions only.
    logic [ITEM_W-1:0]   shelf_pages [SHELF_DEPTH];
    int unsigned         shelf_count = 0;
    logic [RESULT_W-1:0] shelf_total = '0;
    logic [GROUPS_W-1:0] groups_cfg  = GROUPS_W'(1);   // register reset value

    t_book  book_queue[$];       // lists waiting to be driven
    t_split awaited_splits[$];   // predicted results, oldest first

    t_book  next_book;
    t_split seen_split;
    logic   book_taken  = 1'b0;
    bit     idle_on     = 1'b0;
    int     feed_gap    = 0;
    int     drain_gap   = 0;
    int     fail_count  = 0;
    int     quiet_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Bench model
    // ------------------------------------------------------------------------

    // Greedy left-to-right packing under a bound: a new group opens whenever
    // the next book would overflow the current one. Any single book above the
    // bound makes the bound infeasible outright.
    function automatic bit bound_fits(logic [RESULT_W:0] bound);
        int unsigned       used;
        logic [RESULT_W:0] acc;
        used = 1;
        acc  = '0;
        for (int unsigned i = 0; i < shelf_count; i++) begin
            if (shelf_pages[i] > bound)
                return 1'b0;
            if (acc + shelf_pages[i] <= bound) begin
                acc = acc + shelf_pages[i];
            end else begin
                used++;
                acc = shelf_pages[i];
            end
        end
        return used <= groups_cfg;
    endfunction

    // Absorb one accepted book; on the last one, search for the smallest
    // feasible bound over [0, total] and queue the predicted result.
    function automatic void take_book(logic [ITEM_W-1:0] pages, logic last);
        t_split              want;
        logic [RESULT_W:0]   lo;
        logic [RESULT_W:0]   hi;
        logic [RESULT_W:0]   mid;
        logic [RESULT_W-1:0] best;
        // A full store drops the book, but a dropped last book still counts
        // as the end of the list.
        if (shelf_count < SHELF_DEPTH) begin
            shelf_pages[shelf_count] = pages;
            shelf_count++;
            shelf_total = shelf_total + pages;
        end
        if (!last)
            return;
        want.no_solution  = (groups_cfg == 0) || (groups_cfg > shelf_count);
        want.best_max_sum = '0;
        if (!want.no_solution) begin
            lo   = '0;
            hi   = shelf_total;
            best = shelf_total;
            while (lo <= hi) begin
                mid = lo + ((hi - lo) >> 1);
                if (bound_fits(mid)) begin
                    best = mid[RESULT_W-1:0];
                    if (mid == 0)
                        break;
                    hi = mid - 1;
                end else begin
                    lo = mid + 1;
                end
            end
            want.best_max_sum = best;
        end
        awaited_splits.push_back(want);
        shelf_count = 0;
        shelf_total = '0;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: book channel source and result channel ready, both at negedge
    // ------------------------------------------------------------------------

    always @(posedge i_clk) begin
        book_taken <= book_bus.valid && book_bus.ready;
    end

    // A new book is offered only once the current one has been taken. An idle
    // burst may follow any book, so gaps land before last books, mid list and
    // during the search alike.
    always @(negedge i_clk) begin
        if (!book_bus.valid || book_taken) begin
            if (feed_gap != 0) begin
                book_bus.valid <= 1'b0;
                feed_gap <= feed_gap - 1;
            end else if (book_queue.size() != 0) begin
                next_book = book_queue.pop_front();
                book_bus.valid     <= 1'b1;
                book_bus.item_size <= next_book.pages;
                book_bus.is_last   <= next_book.last;
                if (idle_on && $urandom_range(0, 5) == 0)
                    feed_gap <= $urandom_range(1, 19);
            end else begin
                book_bus.valid <= 1'b0;
            end
        end
    end

    // Result backpressure in bursts; always ready when idling is off.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            split_bus.ready <= 1'b0;
        end else if (drain_gap != 0) begin
            split_bus.ready <= 1'b0;
            drain_gap <= drain_gap - 1;
        end else begin
            split_bus.ready <= 1'b1;
            if (idle_on && $urandom_range(0, 3) == 0)
                drain_gap <= $urandom_range(1, 19);
        end
    end

    // ------------------------------------------------------------------------
    // Monitors: sample accepted transactions at posedge
    // ------------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (i_rst_n && cfg_bus.valid && cfg_bus.ready)
            groups_cfg <= cfg_bus.num_groups;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && book_bus.valid && book_bus.ready)
            take_book(book_bus.item_size, book_bus.is_last);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && split_bus.valid && split_bus.ready) begin
            if (awaited_splits.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: best_max_sum=%0d no_solution=%0b",
                             split_bus.best_max_sum, split_bus.no_solution);
            end else begin
                seen_split = awaited_splits.pop_front();
                if (split_bus.best_max_sum !== seen_split.best_max_sum ||
                    split_bus.no_solution !== seen_split.no_solution) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result mismatch: best_max_sum exp %0d got %0d,",
                                 seen_split.best_max_sum, split_bus.best_max_sum,
                                 " no_solution exp %0b got %0b",
                                 seen_split.no_solution, split_bus.no_solution);
                end
            end
        end
    end

    // Watchdog: the longest legal quiet stretch is the search over a full
    // store, up to 27 probes, each a greedy walk over every stored book.
    always @(posedge i_clk) begin
        if ((book_bus.valid && book_bus.ready) || (split_bus.valid && split_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready)) begin
            quiet_count <= 0;
        end else if (quiet_count >= QUIET_LIMIT) begin
            $display("tb_min_max_contiguous_partition_core: errors");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    function automatic void put_book(logic [ITEM_W-1:0] pages, logic last);
        t_book b;
        b.pages = pages;
        b.last  = last;
        book_queue.push_back(b);
    endfunction

    // Page counts weighted toward the edges; the plain random case covers
    // every bit both ways.
    function automatic logic [ITEM_W-1:0] random_pages();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return ITEM_W'($urandom_range(0, 15));
            4:       return ITEM_W'(1) << $urandom_range(0, ITEM_W - 1);
            default: return ITEM_W'($urandom);
        endcase
    endfunction

    // Mostly small group counts so that short lists have an answer, plus the
    // register extremes and out-of-range values.
    function automatic logic [GROUPS_W-1:0] random_groups();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            2:       return GROUPS_W'(SHELF_DEPTH);
            3, 4:    return GROUPS_W'(1);
            5:       return GROUPS_W'($urandom_range(SHELF_DEPTH + 1, 2046));
            default: return GROUPS_W'($urandom_range(2, 8));
        endcase
    endfunction

    // Queue one list and return its length.
    function automatic int queue_list(int len);
        for (int i = 0; i < len; i++)
            put_book(random_pages(), i == len - 1);
        return len;
    endfunction

    // Writes happen only while the core is idle.
    task automatic write_groups(logic [GROUPS_W-1:0] value);
        @(negedge i_clk);
        cfg_bus.valid      <= 1'b1;
        cfg_bus.num_groups <= value;
        @(posedge i_clk);
        while (!cfg_bus.ready)
            @(posedge i_clk);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Wait until every queued book is taken and every result has arrived,
    // then let the clock run on so the core is surely back to idle.
    task automatic settle();
        while (book_queue.size() != 0 || book_bus.valid || awaited_splits.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        int sent;
        int phase_no;
        int lists;
        i_rst_n            = 1'b0;
        book_bus.valid     = 1'b0;
        book_bus.item_size = '0;
        book_bus.is_last   = 1'b0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.num_groups = '0;
        split_bus.ready    = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: one group at its reset value, page extremes.
        put_book('1, 1'b0);
        put_book('0, 1'b0);
        put_book('1, 1'b1);
        put_book('0, 1'b1);       // single zero book, answer zero
        settle();

        // Two groups: more groups than books, all-zero list, big pages,
        // and an ordinary split.
        write_groups(GROUPS_W'(2));
        put_book(ITEM_W'(7), 1'b1);
        put_book('0, 1'b0);
        put_book('0, 1'b1);
        put_book('1, 1'b0);
        put_book(ITEM_W'(1), 1'b0);
        put_book('1, 1'b1);
        put_book(ITEM_W'(3), 1'b0);
        put_book(ITEM_W'(1), 1'b0);
        put_book(ITEM_W'(4), 1'b0);
        put_book(ITEM_W'(1), 1'b0);
        put_book(ITEM_W'(5), 1'b1);
        settle();

        // Zero groups never has a split.
        write_groups('0);
        put_book(ITEM_W'(9), 1'b0);
        put_book(ITEM_W'(9), 1'b1);
        settle();

        write_groups('1);
        put_book(ITEM_W'(1), 1'b1);
        settle();
        sent = 18;

        // Random phases: a group count, then a handful of lists. Phase four
        // overfills the store so the trailing books, last one included, are
        // dropped. The final stretch runs with no idling at all.
        phase_no = 0;
        while (sent < ITEM_TARGET) begin
            idle_on = (sent < ITEM_TARGET - CALM_TAIL) && ($urandom_range(0, 3) != 0);
            if (phase_no == 4) begin
                write_groups(GROUPS_W'(SHELF_DEPTH));
                sent += queue_list(SHELF_DEPTH + $urandom_range(1, 3));
            end else begin
                write_groups(random_groups());
                lists = $urandom_range(3, 8);
                repeat (lists) begin
                    if ($urandom_range(0, 9) == 0)
                        sent += queue_list($urandom_range(13, 40));
                    else
                        sent += queue_list($urandom_range(1, 12));
                end
            end
            settle();
            phase_no++;
        end

        repeat (16) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_min_max_contiguous_partition_core: clean");
        else
            $display("tb_min_max_contiguous_partition_core: errors");
        $finish;
    end

endmodule
